[rtl/assert_macros.svh]
// Assertion macros shared by the line buffer RTL.
// Defining NO_ASSERTIONS removes every checker from the build.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_HOLDS(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_HOLDS(lbl, clk, rstn, expr, msg)
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

[rtl/mtlb_pkg.sv]
// Shared constants, codes, result type and address helper for the line buffer.
// No dependencies; imported by every module of the block.
package mtlb_pkg;

    localparam int LINE_DEPTH     = 64;
    localparam int TERMINAL_COUNT = 4;

    localparam int FILL_W = $clog2(LINE_DEPTH + 1);
    localparam int IDX_W  = $clog2(LINE_DEPTH);
    localparam int TERM_W = (TERMINAL_COUNT > 1) ? $clog2(TERMINAL_COUNT) : 1;
    localparam int ADDR_W = $clog2(TERMINAL_COUNT * LINE_DEPTH);
    localparam int STORE_SIZE = TERMINAL_COUNT * LINE_DEPTH;

    localparam logic [1:0] OP_KEY      = 2'd0;
    localparam logic [1:0] OP_READ     = 2'd1;
    localparam logic [1:0] OP_SET_FLAG = 2'd2;
    localparam logic [1:0] OP_UNUSED   = 2'd3;

    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_REJECTED  = 2'd1;
    localparam logic [1:0] STS_NOT_READY = 2'd2;

    localparam logic [7:0] KEY_NEWLINE   = 8'd10;
    localparam logic [7:0] KEY_BACKSPACE = 8'd8;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] line_byte;
        logic [6:0] byte_count;
        logic       last;
    } t_result;

    function automatic logic [ADDR_W-1:0] line_addr(input logic [TERM_W-1:0] term,
                                                    input logic [IDX_W-1:0]  pos);
        logic [ADDR_W-1:0] base;
        base = ADDR_W'(term) * ADDR_W'(LINE_DEPTH);
        return base + ADDR_W'(pos);
    endfunction

endpackage

[rtl/mtlb_out_reg.sv]
// Output holding register for result items on the master-side stream.
// Depends on mtlb_pkg for the result type.
module mtlb_out_reg import mtlb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_result     i_res,
    output logic        o_ready,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // line_byte [7:0], byte_count [14:8], zero [15]
    output logic [1:0]  m_axis_tuser,  // status [1:0]
    output logic        m_axis_tlast   // last
);

    logic    r_valid;
    t_result r_res;

    assign o_ready = !r_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_push;
        end
        if (o_ready && i_push) begin
            r_res <= i_res;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {1'b0, r_res.byte_count, r_res.line_byte};
    assign m_axis_tuser  = r_res.status;
    assign m_axis_tlast  = r_res.last;

endmodule

[rtl/multi_terminal_line_buffer.sv]
// Top level: per-terminal canonical line buffers held in one byte memory.
// Depends on mtlb_pkg, mtlb_out_reg and assert_macros.svh.
//
//  channel  dir  tdata                            tuser
//  s_axis   in   key_byte[7:0] max_bytes[14:8]    opcode[1:0] terminal[3:2]
//  m_axis   out  line_byte[7:0] byte_count[14:8]  status[1:0], tlast = last
//
// A key, set-flag or rejected item is handled as an update, then a result.
// A read checks the fill level, fetches the final byte when the line is
// neither empty nor full, then sends its result items; a complete line streams
// one byte per cycle when not stalled, a rate set by the memory read port.
// Synchronous reset clears fill levels and reading flags; the byte memory is
// not cleared. Output stalls hold the stream in place without losing items.
`include "assert_macros.svh"
module multi_terminal_line_buffer import mtlb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // key_byte [7:0], max_bytes [14:8], zero [15]
    input  logic [3:0]  s_axis_tuser,  // opcode [1:0], terminal [3:2]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // line_byte [7:0], byte_count [14:8], zero [15]
    output logic [1:0]  m_axis_tuser,  // status [1:0]
    output logic        m_axis_tlast   // last
);

    typedef enum logic [1:0] {ST_IDLE, ST_CHECK, ST_STREAM, ST_RESP} t_state;

    t_state              r_state, n_state;
    logic [FILL_W-1:0]   r_fill [TERMINAL_COUNT];
    logic [FILL_W-1:0]   n_fill [TERMINAL_COUNT];
    logic                r_flag [TERMINAL_COUNT];
    logic                n_flag [TERMINAL_COUNT];
    logic [1:0]          r_term, n_term;
    logic [6:0]          r_max, n_max;
    logic [FILL_W-1:0]   r_idx, n_idx;
    logic [FILL_W-1:0]   r_cnt, n_cnt;
    t_result             r_res, n_res;
    logic [7:0]          r_rdata;

    logic [7:0]          line_mem [STORE_SIZE];

    logic                accept;
    logic [1:0]          in_op;
    logic [1:0]          in_term;
    logic [7:0]          in_key;
    logic [6:0]          in_max;
    logic [1:0]          sel_term;
    logic [6:0]          sel_max;
    logic [TERM_W-1:0]   t_idx;
    logic [FILL_W-1:0]   fill_cur;
    logic                flag_cur;
    logic [FILL_W-1:0]   read_cnt;
    logic                complete;
    logic                stream_last;
    logic                mem_we, mem_re;
    logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
    logic [7:0]          mem_wdata;
    logic                out_push, out_ready;
    t_result             out_res;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign in_op         = s_axis_tuser[1:0];
    assign in_term       = s_axis_tuser[3:2];
    assign in_key        = s_axis_tdata[7:0];
    assign in_max        = s_axis_tdata[14:8];

    assign sel_term    = (r_state == ST_IDLE) ? in_term : r_term;
    assign sel_max     = (r_state == ST_IDLE) ? in_max : r_max;
    assign t_idx       = TERM_W'(sel_term);
    assign fill_cur    = r_fill[t_idx];
    assign flag_cur    = r_flag[t_idx];
    assign read_cnt    = (sel_max < 7'(fill_cur)) ? FILL_W'(sel_max) : fill_cur;
    assign stream_last = (FILL_W'(r_idx + FILL_W'(1)) == r_cnt);

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_flag    = r_flag;
        n_term    = r_term;
        n_max     = r_max;
        n_idx     = r_idx;
        n_cnt     = r_cnt;
        n_res     = r_res;
        complete  = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = line_addr(t_idx, IDX_W'(fill_cur));
        mem_wdata = in_key;
        mem_re    = 1'b0;
        mem_raddr = line_addr(t_idx, IDX_W'(fill_cur - FILL_W'(1)));
        out_push  = 1'b0;
        out_res   = r_res;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_term  = in_term;
                    n_max   = in_max;
                    n_state = ST_RESP;
                    n_res   = '{status: STS_OK, line_byte: 8'd0, byte_count: 7'd0, last: 1'b1};
                    if (int'(in_term) >= TERMINAL_COUNT || in_op == OP_UNUSED) begin
                        n_res.status = STS_REJECTED;
                    end else if (in_op == OP_KEY) begin
                        if (in_key == KEY_NEWLINE && !flag_cur) begin
                            n_fill[t_idx] = '0;
                        end else if (in_key == KEY_BACKSPACE) begin
                            if (fill_cur == '0) begin
                                n_res.status = STS_REJECTED;
                            end else begin
                                n_fill[t_idx] = fill_cur - FILL_W'(1);
                            end
                        end else if ((in_key == KEY_NEWLINE && fill_cur < FILL_W'(LINE_DEPTH))
                                     || fill_cur < FILL_W'(LINE_DEPTH - 1)) begin
                            mem_we        = 1'b1;
                            n_fill[t_idx] = fill_cur + FILL_W'(1);
                        end else begin
                            n_res.status = STS_REJECTED;
                        end
                    end else if (in_op == OP_READ) begin
                        n_flag[t_idx] = 1'b1;
                        if (fill_cur == FILL_W'(LINE_DEPTH)) begin
                            complete = 1'b1;
                        end else if (fill_cur == '0) begin
                            n_res.status = STS_NOT_READY;
                        end else begin
                            mem_re  = 1'b1;
                            n_state = ST_CHECK;
                        end
                    end else begin
                        n_flag[t_idx] = 1'b1;
                    end
                end
            end
            ST_CHECK: begin
                if (r_rdata == KEY_NEWLINE) begin
                    complete = 1'b1;
                end else begin
                    n_res   = '{status: STS_NOT_READY, line_byte: 8'd0, byte_count: 7'd0,
                                last: 1'b1};
                    n_state = ST_RESP;
                end
            end
            ST_STREAM: begin
                out_push = 1'b1;
                out_res  = '{status: STS_OK, line_byte: r_rdata, byte_count: 7'(r_cnt),
                             last: stream_last};
                if (out_ready) begin
                    if (stream_last) begin
                        n_fill[t_idx] = '0;
                        n_flag[t_idx] = 1'b0;
                        n_state       = ST_IDLE;
                    end else begin
                        n_idx     = FILL_W'(r_idx + FILL_W'(1));
                        mem_re    = 1'b1;
                        mem_raddr = line_addr(t_idx, IDX_W'(n_idx));
                    end
                end
            end
            ST_RESP: begin
                out_push = 1'b1;
                if (out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (complete) begin
            if (read_cnt == '0) begin
                n_fill[t_idx] = '0;
                n_flag[t_idx] = 1'b0;
                n_res   = '{status: STS_OK, line_byte: 8'd0, byte_count: 7'd0, last: 1'b1};
                n_state = ST_RESP;
            end else begin
                n_idx     = '0;
                n_cnt     = read_cnt;
                mem_re    = 1'b1;
                mem_raddr = line_addr(t_idx, '0);
                n_state   = ST_STREAM;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            for (int i = 0; i < TERMINAL_COUNT; i++) begin
                r_fill[i] <= '0;
                r_flag[i] <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_flag  <= n_flag;
        end
        r_term <= n_term;
        r_max  <= n_max;
        r_idx  <= n_idx;
        r_cnt  <= n_cnt;
        r_res  <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            line_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= line_mem[mem_raddr];
        end
    end

    mtlb_out_reg u_out_reg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (out_push),
        .i_res         (out_res),
        .o_ready       (out_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    `ASSERT_IMPLIES(a_idx_in_range, i_clk, i_rst_n, r_state == ST_STREAM, r_idx < r_cnt, "stream index past count")
    `ASSERT_HOLDS(a_fill_bound, i_clk, i_rst_n, fill_cur <= FILL_W'(LINE_DEPTH), "fill level above line depth")
    `ASSERT_NEXT(a_line_cleared, i_clk, i_rst_n, r_state == ST_STREAM && out_ready && stream_last, r_fill[TERM_W'(r_term)] == '0 && !r_flag[TERM_W'(r_term)] && r_state == ST_IDLE, "line not emptied after read")
    `ASSERT_IMPLIES(a_no_write_in_read, i_clk, i_rst_n, r_state != ST_IDLE, !mem_we, "memory write outside key handling")

endmodule
